[rtl/crlf_pkg.sv]
// shared constants and types for the crlf line parser
package crlf_pkg;

    // default maximum line length before the count restarts
    localparam int LINE_LEN_DEF = 256;

    // width of the stored angle values
    localparam int VAL_W = 19;

    typedef logic signed [VAL_W-1:0] t_angle;

    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    // keyword patterns, last received byte in the low byte
    localparam logic [63:0] KEY_PITCH = 64'h7069742D3E6C6364;
    localparam logic [63:0] KEY_ROLL  = 64'h726F6C2D3E6C6364;
    localparam logic [63:0] KEY_YAW   = 64'h7961772D3E6C6364;

    // keyword hit bits
    localparam int HIT_PITCH = 0;
    localparam int HIT_ROLL  = 1;
    localparam int HIT_YAW   = 2;

endpackage

[rtl/crlf_line_command_number_parser.sv]
// crlf terminated line receiver with keyword tagged number parsing
//
// Takes one received serial byte per transfer and gathers bytes into lines
// ended by CR LF. Each line is scanned on the fly for the keywords
// "pit->lcd", "rol->lcd" and "yaw->lcd" (scanning stops at the first zero
// byte), and line bytes 8 to 11 are folded into a signed decimal value as
// value*10 + (byte - 0x30), without checking that they are digits. When LF
// follows CR, one result transfer is produced: if the line held 9 to 12
// bytes, every matched angle takes the value; the result carries all three
// stored angles, which of them changed, and the low 8 bits of the line
// length. A CR followed by any other byte discards the line and that byte.
// A line that reaches LINE_LEN bytes restarts empty. Timing: a byte is
// captured in an input register and processed once the result register
// is free or being taken; the block takes one byte per cycle while the
// result side keeps up, and the result of an LF passes through the input
// register and then the result register. While a result waits untaken,
// the byte in the input register waits with it, so the input stalls after
// one more byte until the result is taken.
module crlf_line_command_number_parser #(
    parameter int LINE_LEN = crlf_pkg::LINE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_rx_byte,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [crlf_pkg::VAL_W-1:0] o_pitch_value,
    output logic signed [crlf_pkg::VAL_W-1:0] o_roll_value,
    output logic signed [crlf_pkg::VAL_W-1:0] o_yaw_value,
    output logic                          o_pitch_updated,
    output logic                          o_roll_updated,
    output logic                          o_yaw_updated,
    output logic [7:0]                    o_line_length
);

    // line byte count width; the count stays below LINE_LEN
    localparam int CW = $clog2(LINE_LEN);
    localparam logic [CW:0] CNT_LIM = (CW+1)'(LINE_LEN);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // line state
    logic [CW-1:0]         r_count,  n_count;
    logic                  r_cr_seen, n_cr_seen;
    logic [55:0]           r_recent, n_recent;
    logic [2:0]            r_hits,   n_hits;
    logic                  r_zero,   n_zero;
    crlf_pkg::t_angle      r_acc,    n_acc;
    crlf_pkg::t_angle      r_angle [3];
    crlf_pkg::t_angle      n_angle [3];

    // result register
    logic                  r_out_valid;
    crlf_pkg::t_angle      r_out_angle [3];
    logic [2:0]            r_out_upd;
    logic [7:0]            r_out_len;

    // processing handshake and results of the combinational pass
    logic                  w_advance;
    logic                  w_load;
    logic [2:0]            w_upd;
    logic [63:0]           w_window;
    logic                  w_zero_now;
    logic [CW:0]           w_cnt_inc;
    logic [CW+7:0]         w_cnt_ext;
    logic                  w_len_ok;
    crlf_pkg::t_angle      w_digit;

    // the stage moves when the result register is empty or being drained
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    assign w_window   = {r_recent, r_in_byte};
    assign w_zero_now = r_zero || (r_in_byte == crlf_pkg::CHAR_NUL);
    assign w_cnt_inc  = {1'b0, r_count} + (CW+1)'(1);
    assign w_cnt_ext  = {8'b0, r_count};
    assign w_len_ok   = (r_count >= CW'(9)) && (r_count <= CW'(12));
    // byte minus ascii zero, sign extended
    assign w_digit    = crlf_pkg::VAL_W'($signed({1'b0, r_in_byte})
                        - $signed({1'b0, crlf_pkg::CHAR_ZERO}));

    always_comb begin
        n_count   = r_count;
        n_cr_seen = r_cr_seen;
        n_recent  = r_recent;
        n_hits    = r_hits;
        n_zero    = r_zero;
        n_acc     = r_acc;
        n_angle   = r_angle;
        w_load    = 1'b0;
        w_upd     = 3'b000;

        if (w_advance) begin
            if (r_cr_seen) begin
                if (r_in_byte == crlf_pkg::CHAR_LF) begin
                    // line complete, commit matched angles
                    w_load = 1'b1;
                    if (w_len_ok) begin
                        w_upd = r_hits;
                        for (int k = 0; k < 3; k++) begin
                            if (r_hits[k]) begin
                                n_angle[k] = r_acc;
                            end
                        end
                    end
                end
                // either way the line restarts
                n_count   = '0;
                n_cr_seen = 1'b0;
                n_recent  = '0;
                n_hits    = '0;
                n_zero    = 1'b0;
                n_acc     = '0;
            end else if (r_in_byte == crlf_pkg::CHAR_CR) begin
                n_cr_seen = 1'b1;
            end else begin
                n_zero   = w_zero_now;
                n_recent = w_window[55:0];
                if (!w_zero_now && (r_count >= CW'(7))) begin
                    if (w_window == crlf_pkg::KEY_PITCH) begin
                        n_hits[crlf_pkg::HIT_PITCH] = 1'b1;
                    end
                    if (w_window == crlf_pkg::KEY_ROLL) begin
                        n_hits[crlf_pkg::HIT_ROLL] = 1'b1;
                    end
                    if (w_window == crlf_pkg::KEY_YAW) begin
                        n_hits[crlf_pkg::HIT_YAW] = 1'b1;
                    end
                end
                // digit positions: acc*10 as acc*8 + acc*2
                if ((r_count >= CW'(8)) && (r_count <= CW'(11))) begin
                    n_acc = (r_acc <<< 3) + (r_acc <<< 1) + w_digit;
                end
                if (w_cnt_inc >= CNT_LIM) begin
                    // overflow, start over with an empty line
                    n_count  = '0;
                    n_recent = '0;
                    n_hits   = '0;
                    n_zero   = 1'b0;
                    n_acc    = '0;
                end else begin
                    n_count = w_cnt_inc[CW-1:0];
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cr_seen <= 1'b0;
            r_recent  <= '0;
            r_hits    <= '0;
            r_zero    <= 1'b0;
            r_acc     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_angle[k] <= '0;
            end
        end else begin
            r_count   <= n_count;
            r_cr_seen <= n_cr_seen;
            r_recent  <= n_recent;
            r_hits    <= n_hits;
            r_zero    <= n_zero;
            r_acc     <= n_acc;
            r_angle   <= n_angle;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_angle <= n_angle;
            r_out_upd   <= w_upd;
            r_out_len   <= w_cnt_ext[7:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pitch_value   = r_out_angle[crlf_pkg::HIT_PITCH];
    assign o_roll_value    = r_out_angle[crlf_pkg::HIT_ROLL];
    assign o_yaw_value     = r_out_angle[crlf_pkg::HIT_YAW];
    assign o_pitch_updated = r_out_upd[crlf_pkg::HIT_PITCH];
    assign o_roll_updated  = r_out_upd[crlf_pkg::HIT_ROLL];
    assign o_yaw_updated   = r_out_upd[crlf_pkg::HIT_YAW];
    assign o_line_length   = r_out_len;

    // the count restarts before it reaches the line limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < CNT_LIM)
        else $error("line count passed its limit");

    // a completed line leaves an empty line behind
    a_restart_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_count == '0) && !r_cr_seen && (r_hits == '0))
        else $error("line state not cleared after result");

    // an update only comes from a line of 9 to 12 bytes
    a_update_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pitch_updated || o_roll_updated || o_yaw_updated)
        |-> (o_line_length >= 8'd9) && (o_line_length <= 8'd12))
        else $error("angle update from a line of wrong length");

    // a pending result always shows the stored angles
    a_angles_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_value == r_angle[crlf_pkg::HIT_PITCH])
            && (o_roll_value == r_angle[crlf_pkg::HIT_ROLL])
            && (o_yaw_value == r_angle[crlf_pkg::HIT_YAW]))
        else $error("result angles differ from stored angles");

endmodule

[sim/crlf_line_parser_checker.sv]
// transfer monitor, line result predictor and scoreboard for the crlf line parser
module crlf_line_parser_checker #(
    parameter int LINE_LEN = crlf_pkg::LINE_LEN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [crlf_pkg::VAL_W-1:0] i_pitch_value,
    input  logic signed [crlf_pkg::VAL_W-1:0] i_roll_value,
    input  logic signed [crlf_pkg::VAL_W-1:0] i_yaw_value,
    input  logic                    i_pitch_updated,
    input  logic                    i_roll_updated,
    input  logic                    i_yaw_updated,
    input  logic [7:0]              i_line_length,
    output int                      o_fail_count,
    output int                      o_lines_pending
);

    typedef struct {
        crlf_pkg::t_angle pitch;
        crlf_pkg::t_angle roll;
        crlf_pkg::t_angle yaw;
        logic [2:0]       changed;
        logic [7:0]       length;
    } t_line_result;

    t_line_result expected_lines[$];
    int           mismatches = 0;

    // line being received
    int               line_count;
    bit               cr_pending;
    logic [55:0]      tail_window;
    logic [2:0]       tag_hits;
    bit               nul_in_line;
    int               number_acc;
    crlf_pkg::t_angle angle_store[3];

    task automatic clear_line();
        line_count  = 0;
        cr_pending  = 1'b0;
        tail_window = '0;
        tag_hits    = '0;
        nul_in_line = 1'b0;
        number_acc  = 0;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // fold one accepted byte into the line state, queue a result on CR LF
    task automatic take_byte(input logic [7:0] rx);
        t_line_result res;
        logic [63:0]  win;
        if (cr_pending) begin
            if (rx == crlf_pkg::CHAR_LF) begin
                res.changed = '0;
                if (line_count >= 9 && line_count <= 12) begin
                    for (int k = 0; k < 3; k++) begin
                        if (tag_hits[k]) begin
                            angle_store[k] = crlf_pkg::t_angle'(number_acc);
                            res.changed[k] = 1'b1;
                        end
                    end
                end
                res.pitch  = angle_store[crlf_pkg::HIT_PITCH];
                res.roll   = angle_store[crlf_pkg::HIT_ROLL];
                res.yaw    = angle_store[crlf_pkg::HIT_YAW];
                res.length = line_count[7:0];
                expected_lines.push_back(res);
            end
            // anything but LF after CR throws the line away
            clear_line();
        end else if (rx == crlf_pkg::CHAR_CR) begin
            cr_pending = 1'b1;
        end else begin
            if (rx == crlf_pkg::CHAR_NUL)
                nul_in_line = 1'b1;
            win = {tail_window, rx};
            if (!nul_in_line && line_count >= 7) begin
                if (win == crlf_pkg::KEY_PITCH) tag_hits[crlf_pkg::HIT_PITCH] = 1'b1;
                if (win == crlf_pkg::KEY_ROLL)  tag_hits[crlf_pkg::HIT_ROLL]  = 1'b1;
                if (win == crlf_pkg::KEY_YAW)   tag_hits[crlf_pkg::HIT_YAW]   = 1'b1;
            end
            tail_window = win[55:0];
            if (line_count >= 8 && line_count <= 11)
                number_acc = number_acc * 10 + (int'(rx) - int'(crlf_pkg::CHAR_ZERO));
            line_count++;
            if (line_count >= LINE_LEN)
                clear_line();
        end
    endtask

    task automatic check_result();
        t_line_result want;
        if (expected_lines.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual pitch %0d roll %0d %s",
                     $time, i_pitch_value, i_roll_value, "");
            $display("%0t: unexpected result, actual yaw %0d len %0d",
                     $time, i_yaw_value, i_line_length);
            mismatches++;
        end else begin
            want = expected_lines.pop_front();
            check_field("pitch_value", int'(want.pitch), int'(i_pitch_value));
            check_field("roll_value", int'(want.roll), int'(i_roll_value));
            check_field("yaw_value", int'(want.yaw), int'(i_yaw_value));
            check_field("pitch_updated", int'(want.changed[crlf_pkg::HIT_PITCH]),
                        int'(i_pitch_updated));
            check_field("roll_updated", int'(want.changed[crlf_pkg::HIT_ROLL]),
                        int'(i_roll_updated));
            check_field("yaw_updated", int'(want.changed[crlf_pkg::HIT_YAW]),
                        int'(i_yaw_updated));
            check_field("line_length", int'(want.length), int'(i_line_length));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            for (int k = 0; k < 3; k++)
                angle_store[k] = '0;
            expected_lines.delete();
        end else begin
            // results first: a byte taken at this edge cannot produce one yet
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                take_byte(i_rx_byte);
        end
        o_fail_count    <= mismatches;
        o_lines_pending <= expected_lines.size();
    end

endmodule

[sim/crlf_line_command_number_parser_tb.sv]
// testbench top: byte stimulus, result backpressure and verdict for the crlf line parser
module crlf_line_command_number_parser_tb;

    // way above the slowest legal run of this stimulus
    localparam int CYCLE_LIMIT = 300000;
    // bytes of random stimulus per idling phase
    localparam int PHASE_BYTES = 560;
    // cycles to watch for stray results after the last expected one
    localparam int TAIL_CYCLES = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [7:0]       i_rx_byte = '0;
    logic             i_ready = 1'b0;
    logic             o_ready;
    logic             o_valid;
    crlf_pkg::t_angle o_pitch_value;
    crlf_pkg::t_angle o_roll_value;
    crlf_pkg::t_angle o_yaw_value;
    logic             o_pitch_updated;
    logic             o_roll_updated;
    logic             o_yaw_updated;
    logic [7:0]       o_line_length;

    int         fail_count;
    int         lines_pending;
    int         cycle_count = 0;
    int         send_gap_pct = 0;
    int         ready_stall_pct = 0;
    int         bytes_sent = 0;

    // bytes of the line being built, sent as a burst of transfers
    logic [7:0] line_bytes[$];

    crlf_line_command_number_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pitch_value   (o_pitch_value),
        .o_roll_value    (o_roll_value),
        .o_yaw_value     (o_yaw_value),
        .o_pitch_updated (o_pitch_updated),
        .o_roll_updated  (o_roll_updated),
        .o_yaw_updated   (o_yaw_updated),
        .o_line_length   (o_line_length)
    );

    crlf_line_parser_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_pitch_value   (o_pitch_value),
        .i_roll_value    (o_roll_value),
        .i_yaw_value     (o_yaw_value),
        .i_pitch_updated (o_pitch_updated),
        .i_roll_updated  (o_roll_updated),
        .i_yaw_updated   (o_yaw_updated),
        .i_line_length   (o_line_length),
        .o_fail_count    (fail_count),
        .o_lines_pending (lines_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] rx);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[n])
            send_byte(line_bytes[n]);
        line_bytes.delete();
    endtask

    // hold the sender off until every queued result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (lines_pending != 0);
    endtask

    // plain line text, never a CR so the line keeps going
    task automatic add_text(input int count);
        logic [7:0] rx;
        for (int n = 0; n < count; n++) begin
            do
                rx = 8'($urandom);
            while (rx == crlf_pkg::CHAR_CR);
            line_bytes.push_back(rx);
        end
    endtask

    task automatic add_keyword(input int sel, input bit near_miss);
        logic [63:0] key;
        int          spoil;
        logic [7:0]  flip;
        case (sel)
            crlf_pkg::HIT_PITCH: key = crlf_pkg::KEY_PITCH;
            crlf_pkg::HIT_ROLL:  key = crlf_pkg::KEY_ROLL;
            default:             key = crlf_pkg::KEY_YAW;
        endcase
        spoil = near_miss ? $urandom_range(7) : -1;
        for (int n = 0; n < 8; n++) begin
            flip = (n == spoil) ? 8'h01 << $urandom_range(7) : 8'h00;
            line_bytes.push_back(key[63-8*n -: 8] ^ flip);
        end
    endtask

    // mostly decimal digits, sometimes any non-CR byte
    task automatic add_digits(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85)
                line_bytes.push_back(crlf_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            else
                add_text(1);
        end
    endtask

    task automatic add_crlf();
        line_bytes.push_back(crlf_pkg::CHAR_CR);
        line_bytes.push_back(crlf_pkg::CHAR_LF);
    endtask

    // keyword line of 9 to 12 bytes, or one of a random length now and then
    task automatic add_tagged_line(input bit near_miss);
        int total;
        int lead;
        total = $urandom_range(9, 12);
        lead  = $urandom_range(0, total - 9);
        add_text(lead);
        add_keyword($urandom_range(2), near_miss);
        if ($urandom_range(99) < 20)
            add_digits($urandom_range(0, 6));
        else
            add_digits(total - 8 - lead);
    endtask

    // long line around the overflow point, sometimes with a keyword line after
    task automatic send_long_line();
        add_text($urandom_range(250, 262));
        if ($urandom_range(1))
            add_tagged_line(1'b0);
        add_crlf();
        send_line();
    endtask

    task automatic run_random_phase(input int budget);
        int start;
        int pick;
        start = bytes_sent;
        send_long_line();
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                add_tagged_line(1'b0);
                add_crlf();
            end else if (pick < 68) begin
                add_tagged_line(1'b1);
                add_crlf();
            end else if (pick < 82) begin
                // noise, CR and LF included
                for (int n = $urandom_range(14); n > 0; n--)
                    line_bytes.push_back(8'($urandom));
                add_crlf();
            end else if (pick < 92) begin
                // CR followed by something other than LF
                add_tagged_line(1'b0);
                line_bytes.push_back(crlf_pkg::CHAR_CR);
                line_bytes.push_back($urandom_range(1) ? crlf_pkg::CHAR_CR
                                                       : 8'h41 + 8'($urandom_range(25)));
            end else if (pick < 97) begin
                // zero byte ahead of the keyword stops the scan
                line_bytes.push_back(crlf_pkg::CHAR_NUL);
                add_keyword($urandom_range(2), 1'b0);
                add_digits($urandom_range(0, 3));
                add_crlf();
            end else if (pick < 99) begin
                add_crlf();
            end else begin
                send_long_line();
            end
            send_line();
            if ($urandom_range(99) < 2)
                wait_drained();
        end
    endtask

    task automatic run_directed();
        // empty line
        add_crlf();
        // largest and smallest values the digit fold can give
        add_keyword(crlf_pkg::HIT_PITCH, 1'b0);
        repeat (4) line_bytes.push_back(8'hff);
        add_crlf();
        add_keyword(crlf_pkg::HIT_ROLL, 1'b0);
        repeat (4) line_bytes.push_back(crlf_pkg::CHAR_NUL);
        add_crlf();
        // shortest line that updates
        add_keyword(crlf_pkg::HIT_YAW, 1'b0);
        line_bytes.push_back(crlf_pkg::CHAR_ZERO + 8'd7);
        add_crlf();
        // CR CR drops the line, then an empty line follows
        line_bytes.push_back(crlf_pkg::CHAR_CR);
        line_bytes.push_back(crlf_pkg::CHAR_CR);
        add_crlf();
        // zero byte in front of a keyword
        line_bytes.push_back(crlf_pkg::CHAR_NUL);
        add_keyword(crlf_pkg::HIT_PITCH, 1'b0);
        line_bytes.push_back(crlf_pkg::CHAR_ZERO + 8'd5);
        add_crlf();
        send_line();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver stalling a lot
        send_gap_pct    = 26;
        ready_stall_pct = 61;
        run_directed();
        run_random_phase(PHASE_BYTES);
        wait_drained();

        // the other way round
        send_gap_pct    = 61;
        ready_stall_pct = 26;
        run_random_phase(PHASE_BYTES);
        wait_drained();

        // full rate on both sides
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        run_random_phase(PHASE_BYTES);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/crlf_pkg.sv
rtl/crlf_line_command_number_parser.sv
sim/crlf_line_parser_checker.sv
sim/crlf_line_command_number_parser_tb.sv
